@@ hw/rtl/tsg_pkg.sv @@
// ----------------------------------------------------------------------------
// tsg_pkg: shared types and constants of the trapezoidal setpoint generator
// Holds the controller states, the command group sent to the datapath, the
// register indexes and their reset values.
// ----------------------------------------------------------------------------
package tsg_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RESTART,
    S_ERR,
    S_MUL_LO,
    S_MUL_HI,
    S_SQRT,
    S_VEL,
    S_POS_MUL,
    S_POS_ADD,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic restart;
    logic err;
    logic mul_lo;
    logic mul_hi;
    logic sqrt_step;
    logic vel;
    logic pos_mul;
    logic pos_add;
    logic load_out;
  } dp_cmd_t;

  localparam logic [1:0] REG_MAX_VEL = 2'd0;
  localparam logic [1:0] REG_MAX_ACC = 2'd1;
  localparam logic [1:0] REG_TICK    = 2'd2;

  localparam logic [30:0] MAX_VEL_RST = 31'd65536;
  localparam logic [30:0] MAX_ACC_RST = 31'd65536;
  localparam logic [15:0] TICK_RST    = 16'd66;

  localparam logic [4:0] SQRT_LAST = 5'd31;

  localparam logic signed [34:0] S32_MAX_W = 35'sd2147483647;
  localparam logic signed [34:0] S32_MIN_W = -35'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX_W) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN_W) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/trapezoidal_setpoint_generator.sv @@
// ----------------------------------------------------------------------------
// trapezoidal_setpoint_generator: trapezoidal velocity profile generator
// Each input request carries a target position (in_tdata, signed Q16.16) and
// a restart flag (in_tuser). Each request yields one result on the out_
// stream: the reference position (bits 31:0) and velocity (bits 63:32),
// both signed Q16.16. The limits max_velocity, max_acceleration and
// tick_period are written through cfg_we/cfg_index/cfg_wdata; the user must
// write them only while idle (not enforced here). One request is processed
// at a time. A motion tick runs from acceptance to out_tvalid via error, two
// multiplier passes for the braking radicand, a bit-serial square root, the
// velocity update, the position multiply and add, and the output load. A
// restart request runs via the restart step and the output load. in_tready
// rises again on the edge that registers the result, so the next request is
// taken only after the previous result is loaded. When the receiver stalls,
// the finished result waits in the output register; the next request is taken
// and computed meanwhile, and it waits before its own result is loaded until
// the pending one is taken. Synchronous reset clears the reference state to
// zero and restores the default limits; no result is pending after reset.
// ----------------------------------------------------------------------------
module trapezoidal_setpoint_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] target_position
  input  logic        in_tuser,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] position_ref, [63:32] velocity_ref
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_wdata
);

  tsg_pkg::dp_cmd_t cmd;
  logic [31:0]      position;
  logic [31:0]      velocity;

  tsg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_restart (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  tsg_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_target    (in_tdata),
    .out_position (position),
    .out_velocity (velocity)
  );

  assign out_tdata = {velocity, position};

endmodule

@@ hw/rtl/tsg_datapath.sv @@
// ----------------------------------------------------------------------------
// tsg_datapath: arithmetic of the trapezoidal setpoint generator
// Holds the limit registers, the reference state, a two-pass multiplier for
// the braking radicand and a one-bit-per-cycle integer square root.
// ----------------------------------------------------------------------------
module tsg_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tsg_pkg::dp_cmd_t      cmd,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [30:0]           cfg_wdata,
  input  logic [31:0]           in_target,
  output logic [31:0]           out_position,
  output logic [31:0]           out_velocity
);

  logic [30:0]        max_vel_r;
  logic [30:0]        max_acc_r;
  logic [15:0]        tick_r;
  logic signed [31:0] pos_r;
  logic signed [31:0] vel_r;
  logic signed [31:0] tgt_r;
  logic [32:0]        mag_r;
  logic               err_neg_r;
  logic               err_zero_r;
  logic [30:0]        lim_r;
  logic [47:0]        prod_lo_r;
  logic [63:0]        rad_r;
  logic [32:0]        rem_r;
  logic [31:0]        root_r;
  logic signed [48:0] incp_r;
  logic [31:0]        out_pos_r;
  logic [31:0]        out_vel_r;

  logic signed [32:0] err;
  logic [32:0]        mag;
  logic [31:0]        acc2;
  logic [46:0]        lim_prod;
  logic [47:0]        mul_lo;
  logic [48:0]        mul_hi;
  logic [63:0]        rad;
  logic [34:0]        rem_sh;
  logic [34:0]        trial;
  logic               ge;
  logic [34:0]        rem_diff;
  logic [31:0]        vabs;
  logic signed [32:0] vdes;
  logic signed [33:0] dv;
  logic signed [33:0] limp;
  logic signed [33:0] limn;
  logic signed [33:0] dvc;
  logic signed [34:0] vsum;
  logic signed [48:0] vel_ext;
  logic signed [48:0] tick_ext;
  logic signed [48:0] incp;
  logic signed [32:0] inc;
  logic signed [34:0] psum;

  always_comb begin
    err      = {tgt_r[31], tgt_r} - {pos_r[31], pos_r};
    mag      = err[32] ? (33'd0 - err) : err;
    acc2     = {max_acc_r, 1'b0};
    lim_prod = 47'(max_acc_r) * 47'(tick_r);
    mul_lo   = 48'(acc2) * 48'(mag_r[15:0]);
    mul_hi   = 49'(acc2) * 49'(mag_r[32:16]);
    rad      = 64'(prod_lo_r) + {mul_hi[47:0], 16'd0};

    rem_sh   = {rem_r, rad_r[63:62]};
    trial    = {1'b0, root_r, 2'b01};
    ge       = rem_sh >= trial;
    rem_diff = ge ? (rem_sh - trial) : rem_sh;

    vabs = (root_r < {1'b0, max_vel_r}) ? root_r : {1'b0, max_vel_r};
    if (err_zero_r) begin
      vdes = '0;
    end else if (err_neg_r) begin
      vdes = -$signed({1'b0, vabs});
    end else begin
      vdes = $signed({1'b0, vabs});
    end
    dv   = {vdes[32], vdes} - {{2{vel_r[31]}}, vel_r};
    limp = $signed({3'b000, lim_r});
    limn = -limp;
    if (dv > limp) begin
      dvc = limp;
    end else if (dv < limn) begin
      dvc = limn;
    end else begin
      dvc = dv;
    end
    vsum = {{3{vel_r[31]}}, vel_r} + {dvc[33], dvc};

    vel_ext  = {{17{vel_r[31]}}, vel_r};
    tick_ext = $signed({33'd0, tick_r});
    incp     = vel_ext * tick_ext + 49'sd32768;
    inc      = incp_r[48:16];
    psum     = {{3{pos_r[31]}}, pos_r} + {{2{inc[32]}}, inc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_vel_r <= tsg_pkg::MAX_VEL_RST;
      max_acc_r <= tsg_pkg::MAX_ACC_RST;
      tick_r    <= tsg_pkg::TICK_RST;
      pos_r     <= '0;
      vel_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tsg_pkg::REG_MAX_VEL: max_vel_r <= cfg_wdata;
          tsg_pkg::REG_MAX_ACC: max_acc_r <= cfg_wdata;
          tsg_pkg::REG_TICK:    tick_r    <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (cmd.restart) begin
        pos_r <= tgt_r;
        vel_r <= '0;
      end
      if (cmd.vel) begin
        vel_r <= tsg_pkg::sat32(vsum);
      end
      if (cmd.pos_add) begin
        pos_r <= tsg_pkg::sat32(psum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tgt_r <= in_target;
    end
    if (cmd.err) begin
      mag_r      <= mag;
      err_neg_r  <= err[32];
      err_zero_r <= (err == 33'sd0);
      lim_r      <= lim_prod[46:16];
    end
    if (cmd.mul_lo) begin
      prod_lo_r <= mul_lo;
    end
    if (cmd.mul_hi) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end
    if (cmd.sqrt_step) begin
      rad_r  <= {rad_r[61:0], 2'b00};
      rem_r  <= rem_diff[32:0];
      root_r <= {root_r[30:0], ge};
    end
    if (cmd.pos_mul) begin
      incp_r <= incp;
    end
    if (cmd.load_out) begin
      out_pos_r <= pos_r;
      out_vel_r <= vel_r;
    end
  end

  assign out_position = out_pos_r;
  assign out_velocity = out_vel_r;

endmodule

@@ hw/rtl/tsg_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsg_ctrl: sequencer of the trapezoidal setpoint generator
// Steps the datapath through one control tick and owns both handshakes.
// ----------------------------------------------------------------------------
module tsg_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_restart,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output tsg_pkg::dp_cmd_t cmd
);

  tsg_pkg::state_t state_r;
  tsg_pkg::state_t state_nxt;
  logic [4:0]      cnt_r;
  logic [4:0]      cnt_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tsg_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = in_restart ? tsg_pkg::S_RESTART : tsg_pkg::S_ERR;
        end
      end
      tsg_pkg::S_RESTART: state_nxt = tsg_pkg::S_FINISH;
      tsg_pkg::S_ERR:     state_nxt = tsg_pkg::S_MUL_LO;
      tsg_pkg::S_MUL_LO:  state_nxt = tsg_pkg::S_MUL_HI;
      tsg_pkg::S_MUL_HI:  state_nxt = tsg_pkg::S_SQRT;
      tsg_pkg::S_SQRT: begin
        if (cnt_r == tsg_pkg::SQRT_LAST) begin
          state_nxt = tsg_pkg::S_VEL;
        end
      end
      tsg_pkg::S_VEL:     state_nxt = tsg_pkg::S_POS_MUL;
      tsg_pkg::S_POS_MUL: state_nxt = tsg_pkg::S_POS_ADD;
      tsg_pkg::S_POS_ADD: state_nxt = tsg_pkg::S_FINISH;
      tsg_pkg::S_FINISH: begin
        if (out_free) begin
          state_nxt = tsg_pkg::S_IDLE;
        end
      end
      default: state_nxt = tsg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      tsg_pkg::S_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      tsg_pkg::S_RESTART: cmd.restart = 1'b1;
      tsg_pkg::S_ERR:     cmd.err = 1'b1;
      tsg_pkg::S_MUL_LO:  cmd.mul_lo = 1'b1;
      tsg_pkg::S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        cnt_nxt    = '0;
      end
      tsg_pkg::S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 5'd1;
      end
      tsg_pkg::S_VEL:     cmd.vel = 1'b1;
      tsg_pkg::S_POS_MUL: cmd.pos_mul = 1'b1;
      tsg_pkg::S_POS_ADD: cmd.pos_add = 1'b1;
      tsg_pkg::S_FINISH:  cmd.load_out = out_free;
      default: ;
    endcase
    out_valid_nxt = (out_valid_r && !out_tready) || cmd.load_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsg_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_restart_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_restart) |=> (state_r == tsg_pkg::S_RESTART))
    else $error("Restart request did not take the restart path.");

  a_sqrt_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsg_pkg::S_MUL_HI) |=> (state_r == tsg_pkg::S_SQRT && cnt_r == 5'd0))
    else $error("Square root did not start from a cleared step count.");

  a_sqrt_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsg_pkg::S_SQRT && cnt_r == tsg_pkg::SQRT_LAST) |=>
      (state_r == tsg_pkg::S_VEL))
    else $error("Square root did not end after its last step.");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("Output register overwritten while a result was pending.");

endmodule
